/* rtl/core/two_link_trail_segmenter_unit_assert.svh */
// Assertion macros for the two-link trail segmenter.
// Included by the top level; no other dependencies.
`ifndef TWO_LINK_TRAIL_SEGMENTER_UNIT_ASSERT_SVH
`define TWO_LINK_TRAIL_SEGMENTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TLS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("tls check");
`define TLS_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("tls reset check");
`else
`define TLS_ASSERT(lbl, clk, rstn, prop)
`define TLS_ASSERT_RST(lbl, clk, prop)
`endif
`endif

/* rtl/core/tls_pkg.sv */
// Package for the two-link trail segmenter: types, constants, sine helpers.
// No dependencies.
package tls_pkg;
  localparam int CoordW = 16;
  localparam logic [1:0] KIND_NORMAL = 2'd0;
  localparam logic [1:0] KIND_RIGHT  = 2'd1;
  localparam logic [1:0] KIND_LEFT   = 2'd2;
  localparam logic [2:0] REG_R1 = 3'd0;
  localparam logic [2:0] REG_R2 = 3'd1;
  localparam logic [2:0] REG_CX = 3'd2;
  localparam logic [2:0] REG_CY = 3'd3;
  localparam logic [2:0] REG_SHOW = 3'd4;
  localparam logic [63:0] INV_TWO_PI_Q64 = 64'd2935890503282001226;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  function automatic logic [31:0] coef(input logic [2:0] k);
    case (k)
      3'd0: coef = 32'd1686629713;
      3'd1: coef = 32'd693598668;
      3'd2: coef = 32'd85569305;
      3'd3: coef = 32'd5026995;
      3'd4: coef = 32'd172272;
      3'd5: coef = 32'd3864;
      default: coef = 32'd0;
    endcase
  endfunction

  typedef struct packed {
    logic [23:0] r1;
    logic [23:0] r2;
    logic [11:0] cx;
    logic [11:0] cy;
    logic        show;
  } cfg_t;

  typedef struct packed {
    logic [31:0] ph1;
    logic [31:0] ph2;
    logic [1:0]  section;
    logic        first;
  } front_t;
endpackage

/* rtl/core/tls_front.sv */
// Front: phase and section of each sample from the angles.
// Uses tls_pkg. Multiplies are split in 32-bit partials, a low and a high step per operand.
module tls_front #(
  parameter int AngleFracBits = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [31:0]      a1_i,
  input  logic [31:0]      a2_i,
  input  logic             first_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tls_pkg::front_t  out_o
);
  localparam logic [63:0] Step = (tls_pkg::INV_TWO_PI_Q64 +
    (64'd1 << (AngleFracBits - 1))) >> AngleFracBits;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LO   = 2'd1;
  localparam logic [1:0] S_HI   = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]  st_q, st_d;
  logic [1:0]  idx_q;
  logic [63:0] op_q [3];
  logic [63:0] acc_q [3];
  logic        first_q;
  logic [31:0] a2;
  logic [63:0] mag2;

  assign a2 = a2_i;
  assign mag2 = a2[31] ? (64'd0 - {{32{a2[31]}}, a2}) : {32'd0, a2};
  assign in_ready_o = (st_q == S_IDLE);
  assign out_valid_o = (st_q == S_OUT);
  assign out_o.ph1 = acc_q[0][63:32];
  assign out_o.ph2 = acc_q[1][63:32];
  assign out_o.section = acc_q[2][63:62];
  assign out_o.first = first_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (in_valid_i) st_d = S_LO;
      S_LO: st_d = S_HI;
      S_HI: if (idx_q == 2'd2) st_d = S_OUT; else st_d = S_LO;
      S_OUT: if (out_ready_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      idx_q <= 2'd0;
    end else begin
      st_q <= st_d;
      if (st_q == S_IDLE) idx_q <= 2'd0;
      else if (st_q == S_HI) idx_q <= idx_q + 2'd1;
    end
  end

  // low partial: lo32(op)*Step; high: add (hi32(op)*lo32(Step) + lo32(op)*hi32(Step))<<32
  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: if (in_valid_i) begin
        op_q[0] <= {{32{a1_i[31]}}, a1_i};
        op_q[1] <= {{32{a2[31]}}, a2};
        op_q[2] <= mag2;
        first_q <= first_i;
      end
      S_LO: acc_q[idx_q] <= 64'(op_q[idx_q][31:0] * Step[31:0]);
      S_HI: acc_q[idx_q] <= acc_q[idx_q] +
        {32'(op_q[idx_q][63:32] * Step[31:0] + op_q[idx_q][31:0] * Step[63:32]), 32'd0};
      default: ;
    endcase
  end
endmodule

/* rtl/core/tls_queue.sv */
// Two-entry queue between front and back.
// Uses tls_pkg.
module tls_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tls_pkg::front_t in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tls_pkg::front_t out_o
);
  tls_pkg::front_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_o = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_i;
  end
endmodule

/* rtl/core/tls_back.sv */
// Back: shared sine unit, tip sums, loop counting and segment output.
// Uses tls_pkg. Each Horner step is a multiply state followed by a subtract state.
module tls_back #(
  parameter int CountWidth = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tls_pkg::front_t in_i,
  input  tls_pkg::cfg_t   cfg_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [101:0]    out_o
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_U2   = 4'd1;
  localparam logic [3:0] S_HM   = 4'd2;
  localparam logic [3:0] S_HS   = 4'd3;
  localparam logic [3:0] S_UP   = 4'd4;
  localparam logic [3:0] S_RM   = 4'd5;
  localparam logic [3:0] S_ACC  = 4'd6;
  localparam logic [3:0] S_PIX  = 4'd7;
  localparam logic [3:0] S_UPD  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;
  localparam logic [CountWidth-1:0] CountMax = '1;

  logic [3:0]  st_q, st_d;
  logic [1:0]  fn_q;
  logic [2:0]  k_q;
  tls_pkg::front_t it_q;
  logic [31:0] u_q, u2_q, p_q;
  logic [63:0] prod_q;
  logic        neg_q;
  logic signed [57:0] sx_q, sy_q;
  logic [31:0] phase;
  logic [1:0]  quad;
  logic [29:0] ufrac;
  logic [31:0] sval;
  logic [23:0] reach;
  logic signed [15:0] px_q, py_q, x_q, y_q;
  logic [1:0]  sec_q;
  logic        have_q;
  logic [CountWidth-1:0] lc_q, rc_q;
  logic [1:0]  kind;
  logic [101:0] out_q;

  function automatic logic signed [15:0] pix(input logic signed [57:0] s,
                                              input logic [11:0] c);
    logic [57:0] mag;
    logic signed [17:0] v;
    begin
      mag = s[57] ? 58'(-s) : 58'(s);
      v = s[57] ? -$signed({2'b00, mag[57:42]}) : $signed({2'b00, mag[57:42]});
      v = v + $signed({6'd0, c});
      if (v > 18'sd32767) pix = 16'sh7fff;
      else if (v < -18'sd32768) pix = 16'sh8000;
      else pix = v[15:0];
    end
  endfunction

  // fn 0: sin a1, 1: sin a2, 2: cos a1, 3: cos a2
  always_comb begin
    phase = fn_q[0] ? it_q.ph2 : it_q.ph1;
    if (fn_q[1]) phase = phase + 32'h4000_0000;
    quad = phase[31:30];
    ufrac = phase[29:0];
  end
  assign reach = fn_q[0] ? cfg_i.r2 : cfg_i.r1;
  assign sval = (prod_q[61:30] > 32'h4000_0000) ? 32'h4000_0000 : prod_q[61:30];

  always_comb begin
    kind = tls_pkg::KIND_NORMAL;
    if (sec_q == 2'd1 && it_q.section == 2'd2) kind = tls_pkg::KIND_RIGHT;
    else if (sec_q == 2'd2 && it_q.section == 2'd1) kind = tls_pkg::KIND_LEFT;
  end

  assign in_ready_o = (st_q == S_IDLE);
  assign out_valid_o = (st_q == S_OUT);
  assign out_o = out_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (in_valid_i) st_d = S_U2;
      S_U2: st_d = S_HM;
      S_HM: st_d = S_HS;
      S_HS: st_d = (k_q == 3'd1) ? S_UP : S_HM;
      S_UP: st_d = S_RM;
      S_RM: st_d = S_ACC;
      S_ACC: st_d = (fn_q == 2'd3) ? S_PIX : S_U2;
      S_PIX: st_d = S_UPD;
      S_UPD: st_d = (!it_q.first && have_q) ? S_OUT : S_IDLE;
      S_OUT: if (out_ready_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      fn_q <= 2'd0;
      k_q <= 3'd5;
      px_q <= '0;
      py_q <= '0;
      sec_q <= 2'd0;
      have_q <= 1'b0;
      lc_q <= '0;
      rc_q <= '0;
    end else begin
      st_q <= st_d;
      case (st_q)
        S_IDLE: fn_q <= 2'd0;
        S_U2: k_q <= 3'd5;
        S_HS: k_q <= k_q - 3'd1;
        S_ACC: fn_q <= fn_q + 2'd1;
        S_UPD: begin
          if (it_q.first || !have_q) begin
            lc_q <= '0;
            rc_q <= '0;
          end else begin
            if (kind == tls_pkg::KIND_RIGHT && rc_q != CountMax) rc_q <= rc_q + 1'b1;
            if (kind == tls_pkg::KIND_LEFT && lc_q != CountMax) lc_q <= lc_q + 1'b1;
          end
        end
        S_OUT: ;
        default: ;
      endcase
      if (st_q == S_UPD) begin
        px_q <= x_q;
        py_q <= y_q;
        sec_q <= it_q.section;
        have_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: if (in_valid_i) begin
        it_q <= in_i;
        sx_q <= '0;
        sy_q <= '0;
      end
      S_U2: begin
        u_q <= quad[0] ? (32'h4000_0000 - {2'b00, ufrac}) : {2'b00, ufrac};
        neg_q <= quad[1];
        p_q <= tls_pkg::coef(3'd5);
        prod_q <= 64'((quad[0] ? (32'h4000_0000 - {2'b00, ufrac}) : {2'b00, ufrac})
                      * (quad[0] ? (32'h4000_0000 - {2'b00, ufrac}) : {2'b00, ufrac}));
      end
      S_HM: begin
        if (k_q == 3'd5) begin
          u2_q <= prod_q[61:30];
          prod_q <= 64'(prod_q[61:30] * p_q);
        end else prod_q <= 64'(u2_q * p_q);
      end
      S_HS: p_q <= tls_pkg::coef(k_q - 3'd1) - prod_q[61:30];
      S_UP: prod_q <= 64'(u_q * p_q);
      S_RM: prod_q <= 64'(reach * sval[30:0]);
      S_ACC: begin
        if (fn_q[1]) sy_q <= sy_q + (neg_q ? -$signed({1'b0, prod_q[56:0]})
                                           : $signed({1'b0, prod_q[56:0]}));
        else sx_q <= sx_q + (neg_q ? -$signed({1'b0, prod_q[56:0]})
                                   : $signed({1'b0, prod_q[56:0]}));
      end
      S_PIX: begin
        x_q <= pix(sx_q, cfg_i.cx);
        y_q <= pix(sy_q, cfg_i.cy);
      end
      S_UPD: begin
        out_q[15:0] <= px_q;
        out_q[31:16] <= py_q;
        out_q[47:32] <= x_q;
        out_q[63:48] <= y_q;
        out_q[65:64] <= kind;
        out_q[66] <= cfg_i.show || (kind != tls_pkg::KIND_NORMAL);
        out_q[82:67] <= (lc_q + ((kind == tls_pkg::KIND_LEFT && lc_q != CountMax)
          ? 1'b1 : 1'b0)) > CountWidth'(16'hffff) ? 16'hffff :
          16'(lc_q + ((kind == tls_pkg::KIND_LEFT && lc_q != CountMax) ? 1'b1 : 1'b0));
        out_q[98:83] <= (rc_q + ((kind == tls_pkg::KIND_RIGHT && rc_q != CountMax)
          ? 1'b1 : 1'b0)) > CountWidth'(16'hffff) ? 16'hffff :
          16'(rc_q + ((kind == tls_pkg::KIND_RIGHT && rc_q != CountMax) ? 1'b1 : 1'b0));
        out_q[101:99] <= 3'd0;
      end
      default: ;
    endcase
  end
endmodule

/* rtl/core/two_link_trail_segmenter_unit.sv */
// Channel    | Dir | Beat contents
// s_axis     | in  | tdata: first_angle, second_angle; tuser: first_of_trace
// m_axis     | out | tdata: start_x,start_y,end_x,end_y,segment_kind,draw,loops
// cfg        | in  | cfg_index_i register index, cfg_data_i write data
// Front computes each sample as low and high partial steps; back runs four Horner
// sine passes per sample through one shared sine unit, plus an output state per
// segment, and takes no new sample until done; throughput set by the back sine unit.
// Reset clears control and trace state; a 2-entry queue lets front run ahead.
// Output register holds a segment until taken; back stalls meanwhile.
`include "two_link_trail_segmenter_unit_assert.svh"
module two_link_trail_segmenter_unit #(
  parameter int ANGLE_FRACTION_BITS = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // first_angle, second_angle
  input  logic         s_axis_tuser,  // first_of_trace
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,  // start_x,start_y,end_x,end_y,kind,draw,left,right
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [23:0]  cfg_data_i
);
  tls_pkg::cfg_t   cfg_q;
  tls_pkg::front_t f_out, q_out;
  logic f_v, f_r, q_v, q_r;
  logic [101:0] b_out;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.r1 <= 24'd409600;
      cfg_q.r2 <= 24'd409600;
      cfg_q.cx <= 12'd250;
      cfg_q.cy <= 12'd250;
      cfg_q.show <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tls_pkg::REG_R1: cfg_q.r1 <= cfg_data_i;
        tls_pkg::REG_R2: cfg_q.r2 <= cfg_data_i;
        tls_pkg::REG_CX: cfg_q.cx <= cfg_data_i[11:0];
        tls_pkg::REG_CY: cfg_q.cy <= cfg_data_i[11:0];
        tls_pkg::REG_SHOW: cfg_q.show <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  tls_front #(.AngleFracBits(ANGLE_FRACTION_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .a1_i(s_axis_tdata[31:0]), .a2_i(s_axis_tdata[63:32]), .first_i(s_axis_tuser),
    .out_valid_o(f_v), .out_ready_i(f_r), .out_o(f_out));

  tls_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i(f_v), .in_ready_o(f_r), .in_i(f_out),
    .out_valid_o(q_v), .out_ready_i(q_r), .out_o(q_out));

  tls_back #(.CountWidth(COUNT_WIDTH)) u_back (
    .clk_i, .rst_ni, .in_valid_i(q_v), .in_ready_o(q_r), .in_i(q_out), .cfg_i(cfg_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_o(b_out));

  assign m_axis_tdata = {2'b00, b_out};

  `TLS_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `TLS_ASSERT(a_kind_ok, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[65:64] != 2'd3)
  `TLS_ASSERT(a_draw, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[65:64] != 2'd0 |-> m_axis_tdata[66])
endmodule
